@@ hdl/wpm_pkg.sv @@
// wpm_pkg: request codes, special pattern bytes and word structs
// for the wildcard pattern matcher; no dependencies
`default_nettype none

package wpm_pkg;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_START  = 2'd2,
    REQ_TEXT   = 2'd3
  } req_t;

  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] ANY_CHAR  = 8'h3F;

  typedef struct packed {
    req_t       req;
    logic [7:0] ch;
  } item_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/wpm_star_close.sv @@
// wpm_star_close: closes a prefix bit set over star positions with a
// log-depth parallel prefix network; no package dependency
`default_nettype none

module wpm_star_close #(
  parameter int WIDTH = 65
) (
  input  logic [WIDTH-1:0] seed,
  input  logic [WIDTH-1:0] prop,
  output logic [WIDTH-1:0] closed
);

  localparam int LV = $clog2(WIDTH);

  // closed[k] = seed[k] | prop[k] & closed[k-1]
  logic [WIDTH-1:0] g [LV+1];
  logic [WIDTH-1:0] p [LV+1];

  assign g[0] = seed;
  assign p[0] = prop;

  for (genvar l = 0; l < LV; l++) begin : g_level
    localparam int D = 1 << l;
    for (genvar k = 0; k < WIDTH; k++) begin : g_bit
      if (k >= D) begin : g_comb
        assign g[l+1][k] = g[l][k] | (p[l][k] & g[l][k-D]);
        assign p[l+1][k] = p[l][k] & p[l][k-D];
      end else begin : g_pass
        assign g[l+1][k] = g[l][k];
        assign p[l+1][k] = p[l][k];
      end
    end
  end

  assign closed = g[LV];

endmodule

`default_nettype wire

@@ hdl/wpm_core.sv @@
// wpm_core: pattern store, pattern length and prefix bit set, updated
// once per word; uses wpm_pkg and wpm_star_close
`default_nettype none

module wpm_core #(
  parameter int PATTERN_MAX = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  wpm_pkg::item_t   item,
  output wpm_pkg::result_t result
);

  import wpm_pkg::*;

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam logic [PATTERN_MAX:0] START_SET = {{PATTERN_MAX{1'b0}}, 1'b1};

  logic [7:0]             store [PATTERN_MAX];
  logic [LEN_W-1:0]       len, len_next;
  logic [PATTERN_MAX:0]   reach, reach_next;
  logic [PATTERN_MAX-1:0] en, en_a, star, star_a, hit;
  logic [PATTERN_MAX:0]   step_vec, seed, prop, closed;
  logic                   room, store_wr;
  logic                   new_star;

  assign new_star = (item.ch == STAR_CHAR);

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_pos
    localparam logic [LEN_W-1:0] JPOS = LEN_W'(j);
    assign en[j]     = (JPOS < len);
    assign en_a[j]   = (JPOS <= len);
    assign star[j]   = (store[j] == STAR_CHAR);
    assign star_a[j] = (JPOS == len) ? new_star : star[j];
    assign hit[j]    = (store[j] == item.ch) || (store[j] == ANY_CHAR);
    // one text byte: stars keep their bit, others shift on a hit
    assign step_vec[j+1] = en[j] & (star[j] ? reach[j+1] : (hit[j] & reach[j]));
  end
  assign step_vec[0] = 1'b0;

  assign room = (len < LEN_W'(PATTERN_MAX));

  always_comb begin
    prop[0] = 1'b0;
    if (item.req == REQ_APPEND) begin
      prop[PATTERN_MAX:1] = star_a & en_a;
    end else begin
      prop[PATTERN_MAX:1] = star & en;
    end
    seed = (item.req == REQ_TEXT) ? step_vec : START_SET;
  end

  wpm_star_close #(
    .WIDTH (PATTERN_MAX + 1)
  ) u_close (
    .seed   (seed),
    .prop   (prop),
    .closed (closed)
  );

  always_comb begin
    len_next        = len;
    reach_next      = reach;
    store_wr        = 1'b0;
    result.matched  = 1'b0;
    result.overflow = 1'b0;
    unique case (item.req)
      REQ_CLEAR: begin
        len_next   = '0;
        reach_next = START_SET;
      end
      REQ_APPEND: begin
        if (room) begin
          store_wr   = 1'b1;
          len_next   = len + 1'b1;
          reach_next = closed;
        end else begin
          result.overflow = 1'b1;
        end
      end
      REQ_START, REQ_TEXT: begin
        reach_next     = closed;
        result.matched = closed[len];
      end
      default: begin
        reach_next = reach;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len   <= '0;
      reach <= '0;
    end else if (fire) begin
      len   <= len_next;
      reach <= reach_next;
    end
  end

  // no reset: only entries below len are ever looked at
  always_ff @(posedge clk) begin
    if (fire && store_wr) begin
      store[len[IDX_W-1:0]] <= item.ch;
    end
  end

endmodule

`default_nettype wire

@@ hdl/wildcard_pattern_matcher_top.sv @@
// wildcard_pattern_matcher_top: input register, matcher core, result register
// uses wpm_pkg, wpm_core (and through it wpm_star_close)
`default_nettype none

//  channel | signals                          | direction | moves
//  --------+----------------------------------+-----------+------------------------
//  in      | in_valid in_stall req_type       | sink      | one request word
//          | char_value                       |           |
//  out     | out_valid out_stall matched      | source    | one result word per
//          | pattern_overflow                 |           | request word
//
//  a word is taken into the input register, and once the result register is
//  free or leaving, its whole update runs through the core into the result
//  register; one word per cycle sustained while the output is not stalled
//  the prefix update (compare plus star closure network) is combinational,
//  so any mix of clear, append, start and text words runs at that rate
//  reset (rst, synchronous) empties the pattern and clears the prefix set
//  in_stall rises only while a word waits in the input register and the
//  result register is full and stalled

module wildcard_pattern_matcher_top #(
  parameter int PATTERN_MAX = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic [7:0] char_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       matched,
  output logic       pattern_overflow
);

  import wpm_pkg::*;

  // input register
  logic    item_valid;
  item_t   item;
  result_t result;
  logic    accept;
  logic    advance;

  // word moves into the result register when that register is free or leaving
  assign advance  = item_valid & (~out_valid | ~out_stall);
  assign in_stall = item_valid & ~advance;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      item.req <= req_t'(req_type);
      item.ch  <= char_value;
    end
  end

  // state update happens exactly when the word advances, keeping order
  wpm_core #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (item),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      matched          <= result.matched;
      pattern_overflow <= result.overflow;
    end
  end

endmodule

`default_nettype wire

@@ hdl/wpm_checker.sv @@
// wpm_checker: port-level assertions for the wildcard pattern matcher
// and the bind that attaches them to wildcard_pattern_matcher_top
`default_nettype none

module wpm_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic matched,
  input logic pattern_overflow
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(matched) && $stable(pattern_overflow))
    else $error("result word changed while stalled");

  // a word never reports both a match and an overflow
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(matched && pattern_overflow))
    else $error("matched and pattern_overflow both set");

  // input only backs up behind a stalled full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind wildcard_pattern_matcher_top wpm_checker u_wpm_checker (.*);

`default_nettype wire
